/* src/tone_melody_sequencer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Tone melody sequencer assertion macros
// Shared property shorthands for the sequencer checks.
// ----------------------------------------------------------------------------
`ifndef TONE_MELODY_SEQUENCER_UNIT_DEFINES_SVH
`define TONE_MELODY_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define TMSQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tmsq same-cycle check failed");

// next-cycle implication
`define TMSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tmsq next-cycle check failed");

`endif

/* src/tmsq_pkg.sv */
// ----------------------------------------------------------------------------
// Tone melody sequencer package
// Field widths, codes, payload structs and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tmsq_pkg;

   localparam int CLOCK_HZ_DEF    = 16000000;
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int PRESCALE_DEF    = 1024;

   localparam int MODE_W  = 3;
   localparam int ADDR_W  = 8;
   localparam int FREQ_W  = 13;
   localparam int LEN_W   = 8;
   localparam int TEMPO_W = 10;
   localparam int TICK_W  = 16;
   localparam int ENTRY_W = FREQ_W + LEN_W;
   localparam int PROD_W  = TICK_W + LEN_W;
   localparam int DEN_W   = TEMPO_W + 3;

   localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PLAY_ONCE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PLAY_LOOP  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STOP       = 3'd4;

   localparam logic [FREQ_W-1:0] END_MARK  = 13'd0;
   localparam logic [FREQ_W-1:0] REST_MARK = 13'd1;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [ADDR_W-1:0]  address;
      logic [FREQ_W-1:0]  frequency;
      logic [LEN_W-1:0]   length;
      logic [TEMPO_W-1:0] tempo;
   } req_type;

   typedef struct packed {
      logic [FREQ_W-1:0] tone_hz;
      logic              speaker_enable;
      logic              playing;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_EVAL,
      ST_MUL
   } seq_state_type;

endpackage

`default_nettype wire

/* src/tmsq_ram.sv */
// ----------------------------------------------------------------------------
// Tone melody sequencer RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/tmsq_div.sv */
// ----------------------------------------------------------------------------
// Tone melody sequencer tempo divider
// Restoring divider, one quotient bit per cycle, constant numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsq_div import tmsq_pkg::*; #(
   parameter logic [63:0] NUMER = 64'd937500,
   parameter int          NUM_W = 20
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DEN_W-1:0]  den,
   output logic                   done,
   output logic      [NUM_W-1:0]  quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quot_ff, quot_in;
   logic [DEN_W:0]    rem_sh;
   logic              fits;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      rem_sh  = {rem_ff, quot_ff[NUM_W-1]};
      fits    = rem_sh >= {1'b0, den};
      done    = busy_ff && (cnt_ff == '0);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         quot_in = NUM_W'(NUMER);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in  = cnt_ff - 1'b1;
            rem_in  = fits ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

/* src/tone_melody_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// Tone melody sequencer
// Note table in RAM, tempo divider, note timing and speaker gate.
//
//   channel | ports                          | beat
//   req     | req_valid req_stall req_data   | tick, write, play, stop
//   rsp     | rsp_valid rsp_stall rsp_data   | tone, speaker, playing
//
// Tick, write, stop and unused modes are taken back to back while the result
// is not stalled. Tick at a note end: table read, evaluate, multiply, with a
// second table read on a loop restart; the single RAM read port sets this.
// Play: the bit-serial tempo divider runs, then the first note is read,
// evaluated and multiplied. Reset needs no table sweep; the block is ready at once.
// A stalled result holds; one more beat is taken and waits behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_melody_sequencer_unit import tmsq_pkg::*; #(
   parameter int CLOCK_HZ    = CLOCK_HZ_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int PRESCALE    = PRESCALE_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

`include "tone_melody_sequencer_unit_defines.svh"

   localparam logic [63:0] NUMER = (64'(CLOCK_HZ) * 64'd60) / 64'(PRESCALE);
   localparam int          NUM_W = $clog2(NUMER + 64'd1);
   localparam int          QX_W  = (NUM_W > TICK_W + 1) ? NUM_W : TICK_W + 1;
   localparam int          AW    = $clog2(TABLE_DEPTH);

   seq_state_type state_ff, state_in;

   req_type             item_ff, item_in;
   logic [ADDR_W-1:0]   song_start_ff, song_start_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [TICK_W-1:0]   unit_ff, unit_in;
   logic [TICK_W-1:0]   gap_ff, gap_in;
   logic [TICK_W-1:0]   end_ff, end_in;
   logic [TICK_W-1:0]   sil_ff, sil_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic                loop_ff, loop_in;
   logic                run_ff, run_in;
   logic [FREQ_W-1:0]   tone_ff, tone_in;
   logic                snd_ff, snd_in;
   logic                retry_ff, retry_in;
   logic                oob_ff, oob_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [FREQ_W-1:0]   nfreq_ff, nfreq_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                out_free;
   logic                req_accept;
   logic                exec_play;
   logic                exec_slow;
   logic                exec_fast;
   logic                eval_stop;
   logic                eval_halt;
   logic                done;

   logic                mem_we;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_pos;
   logic [ENTRY_W-1:0]  rd_data;
   logic [ENTRY_W-1:0]  entry;
   logic [FREQ_W-1:0]   entry_freq;
   logic [LEN_W-1:0]    entry_len;

   logic                div_start;
   logic                div_done;
   logic [NUM_W-1:0]    div_quot;
   logic [QX_W-1:0]     quot_x;
   logic [TICK_W-1:0]   end_sat;

   tmsq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_note_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (item_ff.address[AW-1:0]),
      .wr_data ({item_ff.length, item_ff.frequency}),
      .rd_en   (rd_en),
      .rd_addr (rd_pos[AW-1:0]),
      .rd_data (rd_data)
   );

   tmsq_div #(
      .NUMER (NUMER),
      .NUM_W (NUM_W)
   ) u_tempo_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .den   ({item_ff.tempo, 3'b000}),
      .done  (div_done),
      .quot  (div_quot)
   );

   // shared decode
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      exec_play  = (item_ff.mode == MODE_PLAY_ONCE) || (item_ff.mode == MODE_PLAY_LOOP);
      exec_slow  = (item_ff.mode == MODE_TICK) && run_ff && (tick_ff == end_ff);
      exec_fast  = !exec_play && !exec_slow;
      entry      = oob_ff ? '0 : rd_data;
      entry_freq = entry[FREQ_W-1:0];
      entry_len  = entry[ENTRY_W-1:FREQ_W];
      eval_stop  = entry_freq == END_MARK;
      eval_halt  = eval_stop && (!loop_ff || retry_ff);
      req_stall  = !((state_ff == ST_IDLE) ||
                     ((state_ff == ST_EXEC) && exec_fast && out_free));
      req_accept = req_valid && !req_stall;
      quot_x     = QX_W'(div_quot);
      end_sat    = (prod_ff[PROD_W-1:TICK_W] != '0) ? '1 : prod_ff[TICK_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_play) begin
               state_in = ST_DIV;
            end else if (exec_slow) begin
               state_in = ST_EVAL;
            end else if (out_free) begin
               state_in = req_accept ? ST_EXEC : ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!eval_stop) begin
               state_in = ST_MUL;
            end else if (eval_halt && out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_in       = req_accept ? req_data : item_ff;
      song_start_in = song_start_ff;
      pos_in        = pos_ff;
      unit_in       = unit_ff;
      gap_in        = gap_ff;
      end_in        = end_ff;
      sil_in        = sil_ff;
      tick_in       = tick_ff;
      loop_in       = loop_ff;
      run_in        = run_ff;
      tone_in       = tone_ff;
      snd_in        = snd_ff;
      retry_in      = retry_ff;
      prod_in       = prod_ff;
      nfreq_in      = nfreq_ff;
      done          = 1'b0;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      rd_pos        = pos_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_EXEC: begin
            unique case (item_ff.mode) inside
               MODE_TICK: begin
                  if (exec_slow) begin
                     if (tick_ff == sil_ff) snd_in = 1'b0;
                     rd_en    = 1'b1;
                     retry_in = 1'b0;
                  end else if (out_free) begin
                     if (run_ff) begin
                        if (tick_ff == sil_ff) snd_in = 1'b0;
                        tick_in = tick_ff + 1'b1;
                     end
                     done = 1'b1;
                  end
               end
               MODE_WRITE: begin
                  if (out_free) begin
                     mem_we = {1'b0, item_ff.address} < (ADDR_W + 1)'(TABLE_DEPTH);
                     done   = 1'b1;
                  end
               end
               MODE_PLAY_ONCE, MODE_PLAY_LOOP: begin
                  div_start = 1'b1;
               end
               MODE_STOP: begin
                  if (out_free) begin
                     run_in  = 1'b0;
                     loop_in = 1'b0;
                     snd_in  = 1'b0;
                     pos_in  = '0;
                     tick_in = '0;
                     done    = 1'b1;
                  end
               end
               default: begin
                  done = out_free;
               end
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               if (item_ff.tempo == '0) begin
                  unit_in = '1;
               end else if (quot_x == '0) begin
                  unit_in = '0;
               end else if (quot_x > QX_W'(65536)) begin
                  unit_in = '1;
               end else begin
                  unit_in = TICK_W'(quot_x - 1'b1);
               end
               gap_in        = unit_in >> 2;
               song_start_in = item_ff.address;
               pos_in        = item_ff.address;
               loop_in       = item_ff.mode == MODE_PLAY_LOOP;
               run_in        = 1'b1;
               rd_en         = 1'b1;
               rd_pos        = item_ff.address;
               retry_in      = 1'b0;
            end
         end
         ST_EVAL: begin
            if (!eval_stop) begin
               prod_in  = PROD_W'(unit_ff) * PROD_W'(entry_len);
               nfreq_in = entry_freq;
            end else if (eval_halt) begin
               if (out_free) begin
                  run_in  = 1'b0;
                  loop_in = 1'b0;
                  snd_in  = 1'b0;
                  pos_in  = '0;
                  tick_in = '0;
                  done    = 1'b1;
               end
            end else begin
               pos_in   = song_start_ff;
               rd_en    = 1'b1;
               rd_pos   = song_start_ff;
               retry_in = 1'b1;
            end
         end
         ST_MUL: begin
            if (out_free) begin
               end_in  = end_sat;
               sil_in  = (end_sat >= gap_ff) ? end_sat - gap_ff : '0;
               tick_in = '0;
               if (nfreq_ff == REST_MARK) begin
                  snd_in = 1'b0;
               end else begin
                  tone_in = nfreq_ff;
                  snd_in  = 1'b1;
               end
               pos_in = pos_ff + 1'b1;
               done   = 1'b1;
            end
         end
         default: begin
         end
      endcase

      oob_in = rd_en ? ({1'b0, rd_pos} >= (ADDR_W + 1)'(TABLE_DEPTH)) : oob_ff;

      rsp_data_in = rsp_data_ff;
      if (done) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.tone_hz        = tone_in;
         rsp_data_in.speaker_enable = snd_in;
         rsp_data_in.playing        = run_in;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         song_start_ff <= '0;
         pos_ff        <= '0;
         unit_ff       <= '0;
         gap_ff        <= '0;
         end_ff        <= '0;
         sil_ff        <= '0;
         tick_ff       <= '0;
         loop_ff       <= 1'b0;
         run_ff        <= 1'b0;
         tone_ff       <= '0;
         snd_ff        <= 1'b0;
         retry_ff      <= 1'b0;
         oob_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         song_start_ff <= song_start_in;
         pos_ff        <= pos_in;
         unit_ff       <= unit_in;
         gap_ff        <= gap_in;
         end_ff        <= end_in;
         sil_ff        <= sil_in;
         tick_ff       <= tick_in;
         loop_ff       <= loop_in;
         run_ff        <= run_in;
         tone_ff       <= tone_in;
         snd_ff        <= snd_in;
         retry_ff      <= retry_in;
         oob_ff        <= oob_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff     <= item_in;
      prod_ff     <= prod_in;
      nfreq_ff    <= nfreq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TMSQ_ASSERT_NOW(a_speaker_needs_song, clock, reset, rsp_valid,
                    !rsp_data.speaker_enable || rsp_data.playing)
   `TMSQ_ASSERT_NOW(a_div_holds_input, clock, reset, state_ff == ST_DIV, req_stall)
   `TMSQ_ASSERT_NOW(a_div_done_in_div, clock, reset, div_done, state_ff == ST_DIV)
   `TMSQ_ASSERT_NEXT(a_mul_finishes, clock, reset, (state_ff == ST_MUL) && out_free,
                     (state_ff == ST_IDLE) && rsp_valid)

endmodule

`default_nettype wire

/* tb/sv/tone_melody_sequencer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone melody sequencer testbench
// Loads the note table, runs directed songs over the corner cases (wrap,
// rests, end markers, tempo saturation, stop, spare modes), then random song
// runs with random idling on both sides. Every result beat is compared field
// by field against a cycle-free model of the sequencer kept in a scoreboard.
// ----------------------------------------------------------------------------

module tone_melody_sequencer_unit_tb;
   import tmsq_pkg::*;

   localparam int ITEMS_TOTAL = 1550;
   localparam int CALM_LEN    = 200;
   localparam int HOLD_AT     = 600;
   localparam int PAUSE_AT    = 1000;
   localparam int LONG_HOLD   = 250;
   localparam int SETTLE      = 40;
   localparam int MAX_REPORTS = 40;

   localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_STOP + 3'd1;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = '1;

   class melody_tracker;
      logic [ENTRY_W-1:0] notes [TABLE_DEPTH_DEF];
      logic [ADDR_W-1:0]  song_base;
      logic [ADDR_W-1:0]  position;
      logic [TICK_W-1:0]  unit_len;
      logic [TICK_W-1:0]  gap_len;
      logic [TICK_W-1:0]  end_at;
      logic [TICK_W-1:0]  quiet_at;
      logic [TICK_W-1:0]  count;
      logic               looping;
      logic               running;
      logic               sounding;
      logic [FREQ_W-1:0]  tone;
      rsp_type            outputs_due[$];
      int                 errors;

      function new();
         foreach (notes[i]) notes[i] = '0;
         song_base = '0;
         position  = '0;
         unit_len  = '0;
         gap_len   = '0;
         end_at    = '0;
         quiet_at  = '0;
         count     = '0;
         looping   = 1'b0;
         running   = 1'b0;
         sounding  = 1'b0;
         tone      = '0;
         errors    = 0;
      endfunction

      function int pending();
         return outputs_due.size();
      endfunction

      function void halt();
         running  = 1'b0;
         looping  = 1'b0;
         sounding = 1'b0;
         position = '0;
         count    = '0;
      endfunction

      function void next_note();
         logic [ENTRY_W-1:0] entry;
         logic [PROD_W-1:0]  prod;
         entry = notes[position];
         if (entry[FREQ_W-1:0] == END_MARK) begin
            if (!looping) begin
               halt();
               return;
            end
            position = song_base;
            entry    = notes[position];
            if (entry[FREQ_W-1:0] == END_MARK) begin
               halt();
               return;
            end
         end
         prod     = unit_len * entry[ENTRY_W-1:FREQ_W];
         end_at   = (prod > PROD_W'({TICK_W{1'b1}})) ? '1 : prod[TICK_W-1:0];
         quiet_at = (end_at >= gap_len) ? end_at - gap_len : '0;
         count    = '0;
         if (entry[FREQ_W-1:0] == REST_MARK) begin
            sounding = 1'b0;
         end else begin
            tone     = entry[FREQ_W-1:0];
            sounding = 1'b1;
         end
         position = position + 1'b1;
      endfunction

      function logic [TICK_W-1:0] tempo_unit(logic [TEMPO_W-1:0] bpm);
         longint whole;
         longint q;
         whole = longint'(CLOCK_HZ_DEF) * 60 / PRESCALE_DEF;
         if (bpm == 0) return '1;
         q = whole / (longint'(bpm) * 8);
         if (q == 0) return '0;
         if (q - 1 > longint'({TICK_W{1'b1}})) return '1;
         return TICK_W'(q - 1);
      endfunction

      function void start_song(logic [ADDR_W-1:0] base, logic [TEMPO_W-1:0] bpm,
                               logic loop_flag);
         unit_len  = tempo_unit(bpm);
         gap_len   = unit_len / 4;
         song_base = base;
         position  = base;
         looping   = loop_flag;
         running   = 1'b1;
         next_note();
      endfunction

      function void advance_tick();
         if (!running) return;
         if (count == quiet_at) sounding = 1'b0;
         if (count == end_at) next_note();
         else count = count + 1'b1;
      endfunction

      function void apply_command(req_type beat);
         rsp_type want;
         case (beat.mode)
            MODE_TICK:      advance_tick();
            MODE_WRITE:     notes[beat.address] = {beat.length, beat.frequency};
            MODE_PLAY_ONCE: start_song(beat.address, beat.tempo, 1'b0);
            MODE_PLAY_LOOP: start_song(beat.address, beat.tempo, 1'b1);
            MODE_STOP:      halt();
            default: ;
         endcase
         want.tone_hz        = tone;
         want.speaker_enable = sounding;
         want.playing        = running;
         outputs_due.push_back(want);
      endfunction

      function void flag(string field, int want, int got);
         errors++;
         if (errors <= MAX_REPORTS)
            $error("%s expected %0d got %0d", field, want, got);
      endfunction

      function void compare_output(rsp_type got);
         rsp_type want;
         if (outputs_due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $error("result beat with nothing outstanding: %h", got);
            return;
         end
         want = outputs_due.pop_front();
         if (got.tone_hz !== want.tone_hz)
            flag("tone_hz", want.tone_hz, got.tone_hz);
         if (got.speaker_enable !== want.speaker_enable)
            flag("speaker_enable", want.speaker_enable, got.speaker_enable);
         if (got.playing !== want.playing)
            flag("playing", want.playing, got.playing);
      endfunction
   endclass

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   melody_tracker book = new();
   int   beats_sent  = 0;
   logic calm        = 1'b0;
   logic hold_wanted = 1'b0;

   tone_melody_sequencer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(4_000_000);
      $display("[tone_melody_sequencer_unit] ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.compare_output(rsp_data);
   end

   initial begin : receiver_pace
      int held;
      forever begin
         @(negedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            for (held = 0; held < LONG_HOLD; held++) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!reset && !calm && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type filler(logic [MODE_W-1:0] mode);
      req_type beat;
      beat.mode      = mode;
      beat.address   = ADDR_W'($urandom());
      beat.frequency = FREQ_W'($urandom());
      beat.length    = LEN_W'($urandom());
      beat.tempo     = TEMPO_W'($urandom());
      return beat;
   endfunction

   function automatic logic [FREQ_W-1:0] pick_freq();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return END_MARK;
      if (r < 24) return REST_MARK;
      if (r < 28) return '1;
      return FREQ_W'($urandom_range(2, 8191));
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return '0;
      if (r < 80) return LEN_W'(1);
      if (r < 90) return LEN_W'($urandom_range(2, 4));
      return LEN_W'($urandom());
   endfunction

   function automatic logic [TEMPO_W-1:0] song_tempo();
      if ($urandom_range(0, 3) == 0) return TEMPO_W'($urandom());
      return TEMPO_W'($urandom_range(700, 1023));
   endfunction

   task automatic send_beat(input req_type beat);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.apply_command(beat);
      beats_sent++;
      if (beats_sent == HOLD_AT) hold_wanted = 1'b1;
      if (beats_sent >= ITEMS_TOTAL - CALM_LEN) calm = 1'b1;
      @(negedge clock);
   endtask

   task automatic write_note(input logic [ADDR_W-1:0] addr, input logic [FREQ_W-1:0] freq,
                             input logic [LEN_W-1:0] len);
      req_type beat;
      beat           = filler(MODE_WRITE);
      beat.address   = addr;
      beat.frequency = freq;
      beat.length    = len;
      send_beat(beat);
   endtask

   task automatic play_song(input logic [ADDR_W-1:0] base, input logic [TEMPO_W-1:0] bpm,
                            input logic loop_flag);
      req_type beat;
      beat         = filler(loop_flag ? MODE_PLAY_LOOP : MODE_PLAY_ONCE);
      beat.address = base;
      beat.tempo   = bpm;
      send_beat(beat);
   endtask

   task automatic tick_beat();
      send_beat(filler(MODE_TICK));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (book.pending() != 0) @(negedge clock);
   endtask

   task automatic song_run();
      int ticks;
      int r;
      play_song(ADDR_W'($urandom()), song_tempo(), $urandom_range(0, 9) < 7);
      ticks = $urandom_range(40, 320);
      repeat (ticks) begin
         if (beats_sent >= ITEMS_TOTAL) break;
         r = $urandom_range(0, 99);
         if (r < 92) tick_beat();
         else if (r < 97) write_note(ADDR_W'($urandom()), pick_freq(), pick_length());
         else send_beat(filler(MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))));
      end
   endtask

   task automatic noise_run();
      repeat ($urandom_range(10, 30))
         send_beat(filler(MODE_W'($urandom_range(MODE_TICK, MODE_SPARE_HI))));
   endtask

   task automatic stop_run();
      send_beat(filler(MODE_STOP));
      repeat ($urandom_range(3, 12)) tick_beat();
   endtask

   initial begin : stimulus
      int  r;
      bit  paused;
      paused = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int a = 0; a < TABLE_DEPTH_DEF; a++)
         write_note(ADDR_W'(a), pick_freq(), pick_length());

      write_note(8'd10, FREQ_W'(440), 8'd0);
      write_note(8'd11, REST_MARK, 8'd1);
      write_note(8'd12, '1, '1);
      write_note(8'd13, END_MARK, 8'd0);
      play_song(8'd10, '1, 1'b1);
      tick_beat();
      tick_beat();
      write_note(8'd20, END_MARK, '1);
      play_song(8'd20, '1, 1'b1);
      tick_beat();
      play_song(8'd10, '0, 1'b0);
      play_song(8'd10, TEMPO_W'(1), 1'b0);
      tick_beat();
      send_beat(filler(MODE_STOP));
      tick_beat();
      write_note('1, FREQ_W'(300), 8'd0);
      write_note('0, FREQ_W'(5000), 8'd0);
      write_note(8'd1, END_MARK, 8'd0);
      play_song('1, TEMPO_W'(15), 1'b0);
      tick_beat();
      tick_beat();
      send_beat(filler(MODE_SPARE_LO));
      send_beat(filler(MODE_SPARE_LO + 3'd1));
      send_beat(filler(MODE_SPARE_HI));
      wait_drained();

      while (beats_sent < ITEMS_TOTAL) begin
         if (!paused && beats_sent >= PAUSE_AT) begin
            wait_drained();
            paused = 1'b1;
         end
         r = $urandom_range(0, 9);
         if (r < 7) song_run();
         else if (r < 9) noise_run();
         else stop_run();
      end

      wait_drained();
      repeat (SETTLE) @(negedge clock);
      if (book.errors == 0 && book.pending() == 0)
         $display("[tone_melody_sequencer_unit] OK");
      else
         $display("[tone_melody_sequencer_unit] ERROR");
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/tmsq_pkg.sv
src/tmsq_ram.sv
src/tmsq_div.sv
src/tone_melody_sequencer_unit.sv
tb/sv/tone_melody_sequencer_unit_tb.sv
